### hw/rtl/c8ic_pkg.sv
package c8ic_pkg;

	// Sizes
	localparam int MEM_BYTES   = 4096;
	localparam int ADDR_W      = $clog2(MEM_BYTES);
	localparam int STACK_DEPTH = 16;
	localparam int SP_W        = $clog2(STACK_DEPTH);
	localparam int SCR_W       = 64;
	localparam int SCR_H       = 32;
	localparam int ROW_W       = $clog2(SCR_H);
	localparam int FONT_BYTES  = 80;
	localparam logic [ADDR_W-1:0] PC_RESET = ADDR_W'(512);

	// Request codes
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_EXEC  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_ROW   = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_HALT = 2'd1;
	localparam logic [1:0] ST_UNK  = 2'd2;
	localparam logic [1:0] ST_KEY  = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [11:0] address;
		logic [7:0]  write_data;
		logic [7:0]  random_byte;
	} c8ic_req_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic [11:0] program_counter;
		logic [1:0]  status;
		logic        screen_changed;
		logic        sound_active;
	} c8ic_rsp_t;

	// Hex font glyphs, five bytes per digit
	localparam logic [7:0] FONT [FONT_BYTES] = '{
		8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
		8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
		8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
		8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
		8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
		8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
		8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
		8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80
	};

	// Reset content of a memory byte
	function automatic logic [7:0] font_byte(input logic [ADDR_W-1:0] a);
		logic [7:0] r;
		r = 8'd0;
		if (a < ADDR_W'(FONT_BYTES))
			r = FONT[a[6:0]];
		return r;
	endfunction

endpackage

### hw/rtl/chip8_instruction_core.sv
// CHIP-8 instruction core. After reset the core loads the font and clears
// memory and screen (busy high), then takes one transaction per start while
// busy is low. Every transaction gives exactly one result, shown for one cycle
// with done; the receiver cannot stall it. Memory writes and executes on a
// halted core answer in the cycle after start, memory and row reads pass
// through a read state first. An executed instruction runs two fetch reads from
// the single memory port, two register reads, execute and finish; DXYN adds a
// read and a write per sprite row, 00E0 a row-by-row screen clear, FX33 one
// write per BCD digit, FX55 one per register and FX65 a read and write each.
module chip8_instruction_core
	import c8ic_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  c8ic_req_t request,
	output logic      done,
	output c8ic_rsp_t result
);

	typedef enum logic [15:0] {
		S_CLEAR = 16'h0001,
		S_IDLE  = 16'h0002,
		S_F1    = 16'h0004,
		S_F2    = 16'h0008,
		S_F3    = 16'h0010,
		S_EXEC  = 16'h0020,
		S_CLS   = 16'h0040,
		S_DRD   = 16'h0080,
		S_DWR   = 16'h0100,
		S_BCD   = 16'h0200,
		S_STO   = 16'h0400,
		S_LDR   = 16'h0800,
		S_LDW   = 16'h1000,
		S_RDM   = 16'h2000,
		S_RDS   = 16'h4000,
		S_FIN   = 16'h8000
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] ctr_q;
	logic [ADDR_W-1:0] pc_q;
	logic [ADDR_W-1:0] i_q;
	logic [SP_W-1:0]   sp_q;
	logic [ADDR_W-1:0] stk_q [STACK_DEPTH];
	logic [7:0]        v_q [16];
	logic [7:0]        dly_q;
	logic [7:0]        snd_q;
	logic              halt_q;
	logic [15:0]       op_q;
	logic [7:0]        a_q;
	logic [7:0]        b_q;
	logic [7:0]        rnd_q;
	logic [ADDR_W:0]   nxt_q;
	logic [1:0]        st_q;
	logic              chg_q;
	logic              hit_q;
	logic              done_q;
	c8ic_rsp_t         rsp_q;

	// Memory ports
	logic [ADDR_W-1:0] mem_addr;
	logic              mem_we;
	logic [7:0]        mem_wd;
	logic [7:0]        mem_rd;
	logic [ROW_W-1:0]  scr_addr;
	logic              scr_we;
	logic [SCR_W-1:0]  scr_wd;
	logic [SCR_W-1:0]  scr_rd;

	// Decode helpers
	logic [3:0]        op_x, op_y, op_n;
	logic [7:0]        op_nn;
	logic [ADDR_W-1:0] op_nnn;
	logic [ADDR_W-1:0] i_off;
	logic [ADDR_W:0]   pc2, pc4;
	logic [SP_W-1:0]   sp_m1, sp_p1;
	logic [3:0]        v_idx;
	logic [7:0]        v_rd;
	logic [SCR_W-1:0]  spr_base, spr_mask;
	logic              hit_new;
	logic [1:0]        bcd_h;
	logic [6:0]        bcd_rem;
	logic [17:0]       bcd_prod;
	logic [3:0]        bcd_t;
	logic [3:0]        bcd_o;
	logic [7:0]        bcd_dig;
	logic [8:0]        sum_ab;
	logic [ADDR_W:0]   sum_ia;
	logic [7:0]        snd_dec;

	assign op_x   = op_q[11:8];
	assign op_y   = op_q[7:4];
	assign op_n   = op_q[3:0];
	assign op_nn  = op_q[7:0];
	assign op_nnn = op_q[11:0];
	assign i_off  = i_q + {8'd0, ctr_q[3:0]};
	assign pc2    = {1'b0, pc_q} + (ADDR_W+1)'(2);
	assign pc4    = {1'b0, pc_q} + (ADDR_W+1)'(4);
	assign sp_m1  = (sp_q == '0) ? SP_W'(STACK_DEPTH-1) : sp_q - SP_W'(1);
	assign sp_p1  = (sp_q == SP_W'(STACK_DEPTH-1)) ? '0 : sp_q + SP_W'(1);
	assign sum_ab = {1'b0, a_q} + {1'b0, b_q};
	assign sum_ia = {1'b0, i_q} + {5'd0, a_q};
	assign snd_dec = snd_q - {7'd0, (snd_q != 8'd0)};

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = rsp_q;

	// Register file read port
	always_comb begin
		unique case (state_q)
			S_F3:    v_idx = (op_q[15:12] == 4'hB) ? 4'd0 : op_y;
			S_STO:   v_idx = ctr_q[3:0];
			default: v_idx = op_x;
		endcase
	end
	assign v_rd = v_q[v_idx];

	// Sprite row placed at column VX, wrapping
	assign spr_base = {mem_rd, 56'd0};
	assign spr_mask = (spr_base >> a_q[5:0]) | (spr_base << (7'd64 - {1'b0, a_q[5:0]}));
	assign hit_new  = hit_q | (|(scr_rd & spr_mask));

	// Decimal digits of VX
	assign bcd_h    = (a_q >= 8'd200) ? 2'd2 : ((a_q >= 8'd100) ? 2'd1 : 2'd0);
	assign bcd_rem  = 7'(a_q - ((bcd_h == 2'd2) ? 8'd200 : ((bcd_h == 2'd1) ? 8'd100 : 8'd0)));
	assign bcd_prod = {11'd0, bcd_rem} * 18'd205;
	assign bcd_t    = bcd_prod[14:11];
	assign bcd_o    = 4'(bcd_rem - {bcd_t, 3'd0} - {2'd0, bcd_t, 1'b0});
	always_comb begin
		unique case (ctr_q[1:0])
			2'd0:    bcd_dig = {6'd0, bcd_h};
			2'd1:    bcd_dig = {4'd0, bcd_t};
			default: bcd_dig = {4'd0, bcd_o};
		endcase
	end

	// Main memory port steering
	always_comb begin
		mem_addr = i_off;
		mem_we   = 1'b0;
		mem_wd   = bcd_dig;
		unique case (state_q)
			S_CLEAR: begin
				mem_addr = ctr_q;
				mem_we   = 1'b1;
				mem_wd   = font_byte(ctr_q);
			end
			S_IDLE: begin
				mem_addr = (request.req_type == REQ_EXEC) ? pc_q : request.address;
				mem_we   = start && (request.req_type == REQ_WRITE);
				mem_wd   = request.write_data;
			end
			S_F1:  mem_addr = pc_q + ADDR_W'(1);
			S_BCD: mem_we = 1'b1;
			S_STO: begin
				mem_we = 1'b1;
				mem_wd = v_rd;
			end
			default: ;
		endcase
	end

	// Screen memory port steering
	always_comb begin
		scr_addr = b_q[ROW_W-1:0] + ctr_q[ROW_W-1:0];
		scr_we   = 1'b0;
		scr_wd   = '0;
		unique case (state_q)
			S_CLEAR: begin
				scr_addr = ctr_q[ROW_W-1:0];
				scr_we   = (ctr_q[ADDR_W-1:ROW_W] == '0);
			end
			S_CLS: begin
				scr_addr = ctr_q[ROW_W-1:0];
				scr_we   = 1'b1;
			end
			S_IDLE: scr_addr = request.address[ROW_W-1:0];
			S_DWR: begin
				scr_we = 1'b1;
				scr_wd = scr_rd ^ spr_mask;
			end
			default: ;
		endcase
	end

	c8ic_ram #(.DEPTH(MEM_BYTES), .WIDTH(8)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wd),
		.rdata (mem_rd)
	);

	c8ic_ram #(.DEPTH(SCR_H), .WIDTH(SCR_W)) u_scr (
		.clk   (clk),
		.we    (scr_we),
		.addr  (scr_addr),
		.wdata (scr_wd),
		.rdata (scr_rd)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ctr_q   <= '0;
			pc_q    <= PC_RESET;
			i_q     <= '0;
			sp_q    <= '0;
			dly_q   <= '0;
			snd_q   <= '0;
			halt_q  <= 1'b0;
			done_q  <= 1'b0;
			for (int k = 0; k < STACK_DEPTH; k++)
				stk_q[k] <= '0;
			for (int k = 0; k < 16; k++)
				v_q[k] <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					ctr_q <= ctr_q + ADDR_W'(1);
					if (ctr_q == ADDR_W'(MEM_BYTES-1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					rsp_q.read_data       <= '0;
					rsp_q.program_counter <= pc_q;
					rsp_q.status          <= halt_q ? ST_HALT : ST_OK;
					rsp_q.screen_changed  <= 1'b0;
					rsp_q.sound_active    <= (snd_q != 8'd0);
					rnd_q <= request.random_byte;
					if (start) begin
						unique case (request.req_type)
							REQ_WRITE: done_q <= 1'b1;
							REQ_EXEC: begin
								if (halt_q)
									done_q <= 1'b1;
								else
									state_q <= S_F1;
							end
							REQ_READ: state_q <= S_RDM;
							default:  state_q <= S_RDS;
						endcase
					end
				end
				S_RDM: begin
					rsp_q.read_data <= {56'd0, mem_rd};
					done_q          <= 1'b1;
					state_q         <= S_IDLE;
				end
				S_RDS: begin
					rsp_q.read_data <= scr_rd;
					done_q          <= 1'b1;
					state_q         <= S_IDLE;
				end
				S_F1: begin
					op_q[15:8] <= mem_rd;
					state_q    <= S_F2;
				end
				S_F2: begin
					op_q[7:0] <= mem_rd;
					a_q       <= v_rd;
					state_q   <= S_F3;
				end
				S_F3: begin
					b_q     <= v_rd;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					nxt_q   <= pc2;
					st_q    <= ST_OK;
					chg_q   <= 1'b0;
					ctr_q   <= '0;
					hit_q   <= 1'b0;
					state_q <= S_FIN;
					unique case (op_q[15:12])
						4'h0: begin
							if (op_nn == 8'hE0) begin
								chg_q   <= 1'b1;
								state_q <= S_CLS;
							end else if (op_nn == 8'hEE) begin
								sp_q  <= sp_m1;
								nxt_q <= {1'b0, stk_q[sp_m1]} + (ADDR_W+1)'(2);
							end else begin
								st_q  <= ST_UNK;
								nxt_q <= {1'b0, pc_q};
							end
						end
						4'h1: nxt_q <= {1'b0, op_nnn};
						4'h2: begin
							stk_q[sp_q] <= pc_q;
							sp_q        <= sp_p1;
							nxt_q       <= {1'b0, op_nnn};
						end
						4'h3: if (a_q == op_nn) nxt_q <= pc4;
						4'h4: if (a_q != op_nn) nxt_q <= pc4;
						4'h5: if (a_q == b_q) nxt_q <= pc4;
						4'h6: v_q[op_x] <= op_nn;
						4'h7: v_q[op_x] <= a_q + op_nn;
						4'h8: begin
							unique case (op_n)
								4'h0: v_q[op_x] <= b_q;
								4'h1: v_q[op_x] <= a_q | b_q;
								4'h2: v_q[op_x] <= a_q & b_q;
								4'h3: v_q[op_x] <= a_q ^ b_q;
								4'h4: begin
									v_q[op_x] <= sum_ab[7:0];
									v_q[15]   <= {7'd0, sum_ab[8]};
								end
								4'h5: begin
									v_q[op_x] <= a_q - b_q;
									v_q[15]   <= {7'd0, (a_q >= b_q)};
								end
								4'h6: begin
									v_q[op_x] <= {1'b0, a_q[7:1]};
									v_q[15]   <= {7'd0, a_q[0]};
								end
								4'h7: begin
									v_q[op_x] <= b_q - a_q;
									v_q[15]   <= {7'd0, (b_q >= a_q)};
								end
								4'hE: begin
									v_q[op_x] <= {a_q[6:0], 1'b0};
									v_q[15]   <= {7'd0, a_q[7]};
								end
								default: begin
									st_q  <= ST_UNK;
									nxt_q <= {1'b0, pc_q};
								end
							endcase
						end
						4'h9: if (a_q != b_q) nxt_q <= pc4;
						4'hA: i_q <= op_nnn;
						4'hB: nxt_q <= {1'b0, op_nnn} + {5'd0, b_q};
						4'hC: v_q[op_x] <= rnd_q & op_nn;
						4'hD: begin
							chg_q <= 1'b1;
							if (op_n == 4'd0)
								v_q[15] <= 8'd0;
							else
								state_q <= S_DRD;
						end
						4'hE: begin
							if (op_nn == 8'h9E)
								nxt_q <= pc2;
							else if (op_nn == 8'hA1)
								nxt_q <= pc4;
							else begin
								st_q  <= ST_UNK;
								nxt_q <= {1'b0, pc_q};
							end
						end
						default: begin
							unique case (op_nn)
								8'h07: v_q[op_x] <= dly_q;
								8'h0A: begin
									st_q  <= ST_KEY;
									nxt_q <= {1'b0, pc_q};
								end
								8'h15: dly_q <= a_q;
								8'h18: snd_q <= a_q;
								8'h1E: begin
									v_q[15] <= {7'd0, sum_ia[ADDR_W]};
									i_q     <= sum_ia[ADDR_W-1:0];
								end
								8'h29: i_q <= {1'b0, ({3'd0, a_q} + {1'b0, a_q, 2'd0})};
								8'h33: state_q <= S_BCD;
								8'h55: state_q <= S_STO;
								8'h65: state_q <= S_LDR;
								default: begin
									st_q  <= ST_UNK;
									nxt_q <= {1'b0, pc_q};
								end
							endcase
						end
					endcase
				end
				S_CLS: begin
					ctr_q <= ctr_q + ADDR_W'(1);
					if (ctr_q[ROW_W-1:0] == ROW_W'(SCR_H-1))
						state_q <= S_FIN;
				end
				S_DRD: state_q <= S_DWR;
				S_DWR: begin
					hit_q <= hit_new;
					ctr_q <= ctr_q + ADDR_W'(1);
					if (ctr_q[3:0] == op_n - 4'd1) begin
						v_q[15] <= {7'd0, hit_new};
						state_q <= S_FIN;
					end else
						state_q <= S_DRD;
				end
				S_BCD: begin
					ctr_q <= ctr_q + ADDR_W'(1);
					if (ctr_q[1:0] == 2'd2)
						state_q <= S_FIN;
				end
				S_STO: begin
					ctr_q <= ctr_q + ADDR_W'(1);
					if (ctr_q[3:0] == op_x) begin
						i_q     <= i_q + {8'd0, op_x} + ADDR_W'(1);
						state_q <= S_FIN;
					end
				end
				S_LDR: state_q <= S_LDW;
				S_LDW: begin
					v_q[ctr_q[3:0]] <= mem_rd;
					ctr_q           <= ctr_q + ADDR_W'(1);
					if (ctr_q[3:0] == op_x) begin
						i_q     <= i_q + {8'd0, op_x} + ADDR_W'(1);
						state_q <= S_FIN;
					end else
						state_q <= S_LDR;
				end
				S_FIN: begin
					dly_q  <= dly_q - {7'd0, (dly_q != 8'd0)};
					snd_q  <= snd_dec;
					halt_q <= nxt_q[ADDR_W];
					pc_q   <= nxt_q[ADDR_W-1:0];
					rsp_q.read_data       <= '0;
					rsp_q.program_counter <= nxt_q[ADDR_W-1:0];
					rsp_q.status          <= nxt_q[ADDR_W] ? ST_HALT : st_q;
					rsp_q.screen_changed  <= chg_q;
					rsp_q.sound_active    <= (snd_dec != 8'd0);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/c8ic_ram.sv
module c8ic_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port, read-before-write, registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

### hw/rtl/c8ic_checker.sv
module c8ic_checker
	import c8ic_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input c8ic_rsp_t result
);

	// Every result follows an accepted transaction or busy work
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy) || $past(busy)))
		else $error("result without a transaction");

	// Halt is sticky across back-to-back results
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_HALT) |=> (!done || result.status == ST_HALT))
		else $error("halt status dropped");

	// A screen update never comes with unknown opcode or key wait
	a_chg_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.screen_changed) |->
			(result.status == ST_OK || result.status == ST_HALT))
		else $error("screen change with bad status");

	// A halted result does not move the program counter on a back-to-back result
	a_halt_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_HALT) ##1 done |-> $stable(result.program_counter))
		else $error("program counter moved while halted");

endmodule

bind chip8_instruction_core c8ic_checker u_c8ic_checker (.*);

### tb/sv/tb_chip8_instruction_core.sv
module tb_chip8_instruction_core;
	timeunit 1ns;
	timeprecision 1ps;
	import c8ic_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	c8ic_req_t request;
	logic      done;
	c8ic_rsp_t result;

	chip8_instruction_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .done(done), .result(result)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Predictor state
	logic [7:0]  mem_m [MEM_BYTES];
	logic [63:0] scr_m [SCR_H];
	logic [7:0]  v_m [16];
	logic [11:0] stk_m [STACK_DEPTH];
	int unsigned sp_m;
	logic [11:0] idx_m;
	logic [11:0] pc_m;
	logic [7:0]  dly_m;
	logic [7:0]  snd_m;
	bit          halt_m;

	c8ic_req_t pending_q [$];
	c8ic_rsp_t expected_q [$];
	int  mismatches;
	int  results_seen;
	int  exec_count;
	int  draw_count;
	bit  calm;

	task automatic model_reset();
		for (int i = 0; i < MEM_BYTES; i++) mem_m[i] = (i < FONT_BYTES) ? FONT[i] : 8'd0;
		for (int i = 0; i < SCR_H; i++) scr_m[i] = '0;
		for (int i = 0; i < 16; i++) v_m[i] = '0;
		for (int i = 0; i < STACK_DEPTH; i++) stk_m[i] = '0;
		sp_m = 0; idx_m = '0; pc_m = PC_RESET; dly_m = '0; snd_m = '0; halt_m = 1'b0;
	endtask

	// Execute one instruction at the program counter
	function automatic logic [1:0] run_instr(input logic [7:0] rnd, output bit chg);
		logic [15:0] op;
		logic [3:0]  x, y;
		logic [7:0]  nn, a, b, bits;
		logic [11:0] nnn;
		int unsigned nxt, s;
		logic [1:0]  st;
		logic [63:0] pix;
		bit          hit;
		op = {mem_m[pc_m], mem_m[pc_m + 12'd1]};
		x = op[11:8]; y = op[7:4]; nn = op[7:0]; nnn = op[11:0];
		a = v_m[x]; b = v_m[y];
		nxt = pc_m + 2; st = ST_OK; chg = 0;
		case (op[15:12])
			4'h0: begin
				if (nn == 8'hE0) begin
					for (int i = 0; i < SCR_H; i++) scr_m[i] = '0;
					chg = 1;
				end else if (nn == 8'hEE) begin
					sp_m = (sp_m + STACK_DEPTH - 1) % STACK_DEPTH;
					nxt = stk_m[sp_m] + 2;
				end else begin
					st = ST_UNK; nxt = pc_m;
				end
			end
			4'h1: nxt = nnn;
			4'h2: begin
				stk_m[sp_m] = pc_m;
				sp_m = (sp_m + 1) % STACK_DEPTH;
				nxt = nnn;
			end
			4'h3: if (a == nn) nxt = pc_m + 4;
			4'h4: if (a != nn) nxt = pc_m + 4;
			4'h5: if (a == b) nxt = pc_m + 4;
			4'h6: v_m[x] = nn;
			4'h7: v_m[x] = a + nn;
			4'h8: begin
				case (op[3:0])
					4'h0: v_m[x] = b;
					4'h1: v_m[x] = a | b;
					4'h2: v_m[x] = a & b;
					4'h3: v_m[x] = a ^ b;
					4'h4: begin v_m[x] = a + b; v_m[15] = ({1'b0, a} + b) > 9'hFF; end
					4'h5: begin v_m[x] = a - b; v_m[15] = a >= b; end
					4'h6: begin v_m[x] = a >> 1; v_m[15] = a[0]; end
					4'h7: begin v_m[x] = b - a; v_m[15] = b >= a; end
					4'hE: begin v_m[x] = a << 1; v_m[15] = a[7]; end
					default: begin st = ST_UNK; nxt = pc_m; end
				endcase
			end
			4'h9: if (a != b) nxt = pc_m + 4;
			4'hA: idx_m = nnn;
			4'hB: nxt = nnn + v_m[0];
			4'hC: v_m[x] = rnd & nn;
			4'hD: begin
				hit = 0;
				for (int r = 0; r < op[3:0]; r++) begin
					bits = mem_m[idx_m + 12'(r)];
					for (int c = 0; c < 8; c++) begin
						if (bits[7 - c]) begin
							pix = 64'd1 << (63 - ((a + c) % 64));
							if (scr_m[(b + r) % 32] & pix) hit = 1;
							scr_m[(b + r) % 32] ^= pix;
						end
					end
				end
				v_m[15] = hit;
				chg = 1;
			end
			4'hE: begin
				if (nn == 8'hA1) nxt = pc_m + 4;
				else if (nn != 8'h9E) begin st = ST_UNK; nxt = pc_m; end
			end
			default: begin
				case (nn)
					8'h07: v_m[x] = dly_m;
					8'h0A: begin st = ST_KEY; nxt = pc_m; end
					8'h15: dly_m = a;
					8'h18: snd_m = a;
					8'h1E: begin
						s = idx_m + a;
						v_m[15] = s > 12'hFFF;
						idx_m = s[11:0];
					end
					8'h29: idx_m = a * 5;
					8'h33: begin
						mem_m[idx_m] = a / 100;
						mem_m[idx_m + 12'd1] = (a / 10) % 10;
						mem_m[idx_m + 12'd2] = a % 10;
					end
					8'h55: begin
						for (int i = 0; i <= x; i++) mem_m[idx_m + 12'(i)] = v_m[i];
						idx_m = idx_m + x + 12'd1;
					end
					8'h65: begin
						for (int i = 0; i <= x; i++) v_m[i] = mem_m[idx_m + 12'(i)];
						idx_m = idx_m + x + 12'd1;
					end
					default: begin st = ST_UNK; nxt = pc_m; end
				endcase
			end
		endcase
		if (dly_m != 0) dly_m--;
		if (snd_m != 0) snd_m--;
		if (nxt >= MEM_BYTES) begin halt_m = 1; st = ST_HALT; end
		pc_m = nxt[11:0];
		return st;
	endfunction

	// Expected response for one accepted transaction
	function automatic c8ic_rsp_t predict_response(input c8ic_req_t rq);
		c8ic_rsp_t rs;
		bit chg;
		logic [1:0] st;
		rs = '0; st = ST_OK; chg = 0;
		case (rq.req_type)
			REQ_WRITE: mem_m[rq.address] = rq.write_data;
			REQ_EXEC: begin
				if (!halt_m) begin
					st = run_instr(rq.random_byte, chg);
					exec_count++;
					if (chg) draw_count++;
				end
			end
			REQ_READ: rs.read_data = {56'd0, mem_m[rq.address]};
			default: rs.read_data = scr_m[rq.address[4:0]];
		endcase
		rs.program_counter = pc_m;
		rs.status = halt_m ? ST_HALT : st;
		rs.screen_changed = chg;
		rs.sound_active = snd_m != 0;
		return rs;
	endfunction

	function automatic c8ic_req_t mk(input logic [1:0] t, input int ad, input int wd,
			input int rnd);
		c8ic_req_t r;
		r.req_type = t; r.address = 12'(ad); r.write_data = 8'(wd); r.random_byte = 8'(rnd);
		return r;
	endfunction

	task automatic put_op(inout int ad, input logic [15:0] op);
		pending_q.push_back(mk(REQ_WRITE, ad, op[15:8], $urandom_range(0, 254)));
		pending_q.push_back(mk(REQ_WRITE, (ad + 1) % MEM_BYTES, op[7:0], $urandom_range(0, 254)));
		ad = (ad + 2) % MEM_BYTES;
	endtask

	task automatic put_exec(input int n);
		for (int i = 0; i < n; i++)
			pending_q.push_back(mk(REQ_EXEC, $urandom_range(0, 4095), $urandom_range(0, 255),
				$urandom_range(0, 254)));
	endtask

	// Random opcode, mostly well-formed; halting jumps and key waits are kept rare
	function automatic logic [15:0] rand_op();
		logic [15:0] op;
		int k;
		op = $urandom_range(0, 16'hFFFF);
		k = $urandom_range(0, 99);
		if (k < 4) op[15:12] = 4'h1;
		else if (op[15:12] == 4'hB) op[11:8] = 4'h2;
		if (op[15:12] == 4'h1 || op[15:12] == 4'h2) op[11:0] = 12'h200 + $urandom_range(0, 60) * 2;
		if (op[15:12] == 4'hF) begin
			case ($urandom_range(0, 9))
				0: op[7:0] = 8'h07; 1: op[7:0] = 8'h15; 2: op[7:0] = 8'h18;
				3: op[7:0] = 8'h1E; 4: op[7:0] = 8'h29; 5: op[7:0] = 8'h33;
				6: op[7:0] = 8'h55; 7: op[7:0] = 8'h65; 8: op[7:0] = 8'h0A;
				default: ;
			endcase
		end
		if (op[15:12] == 4'h0 && k < 50) op[7:0] = (k < 25) ? 8'hEE : 8'hE0;
		if (op[15:12] == 4'hE && k < 80) op[7:0] = (k < 40) ? 8'h9E : 8'hA1;
		if (op[15:12] == 4'h8 && k < 85) op[3:0] = $urandom_range(0, 7);
		return op;
	endfunction

	// Stimulus
	initial begin
		int ad;
		logic [15:0] dir_ops [] = '{16'h60FF, 16'h61FF, 16'h8014, 16'h8FE6, 16'h7F01,
			16'h00E0, 16'hA000, 16'hD01F, 16'hD01F, 16'hF029, 16'hF033, 16'hFF55,
			16'hFF65, 16'hF11E, 16'hE09E, 16'hE0A1, 16'hF00A, 16'h0123, 16'h800F,
			16'hC0FF};
		ad = 512;
		foreach (dir_ops[i]) put_op(ad, dir_ops[i]);
		put_exec(dir_ops.size());
		pending_q.push_back(mk(REQ_READ, 4095, 0, 0));
		pending_q.push_back(mk(REQ_ROW, 12'hFFF, 0, 0));
		pending_q.push_back(mk(REQ_WRITE, 4095, 255, 254));
		// Random programs: load a block of opcodes, then run it
		while (pending_q.size() < 1250) begin
			int n;
			n = $urandom_range(4, 30);
			ad = 512;
			for (int i = 0; i < n; i++) put_op(ad, rand_op());
			pending_q.push_back(mk(REQ_WRITE, $urandom_range(80, 511), $urandom_range(0, 255),
				$urandom_range(0, 254)));
			put_exec($urandom_range(n, 2 * n));
			pending_q.push_back(mk(REQ_READ, $urandom_range(0, 4095), 0, 0));
			pending_q.push_back(mk(REQ_ROW, $urandom_range(0, 4095), 0, 0));
			// Steer the PC back into the program area
			ad = $urandom_range(0, 60) * 2 + 512;
			pending_q.push_back(mk(REQ_WRITE, ad, 8'h12, 0));
			pending_q.push_back(mk(REQ_WRITE, ad + 1, 8'h00, 0));
		end
		// Finally halt the core: jump to 0xFFE then run off the end
		ad = 512;
		put_op(ad, 16'h1FFE);
		pending_q.push_back(mk(REQ_WRITE, 12'hFFE, 8'h60, 0));
		pending_q.push_back(mk(REQ_WRITE, 12'hFFF, 8'h00, 0));
		for (int i = 0; i < 64; i++) put_exec(1);
		put_exec(20);
		pending_q.push_back(mk(REQ_WRITE, 12'h300, 8'hAA, 0));
		pending_q.push_back(mk(REQ_READ, 12'h300, 0, 0));
	end

	// Reset
	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	// Driver: a new transaction is presented only while busy is low, so the one
	// on the ports is always taken at the next rising edge
	int idle_left;
	int sent;
	initial begin
		start = 1'b0; request = '0; idle_left = 0; sent = 0; calm = 0;
		model_reset();
	end

	always @(negedge clk) begin
		if (arst_n && !busy) begin
			if (start) sent <= sent + 1;
			if (idle_left > 0) begin
				idle_left <= idle_left - 1;
				start <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				idle_left <= $urandom_range(1, 16) - 1;
				start <= 1'b0;
			end else if (pending_q.size() > 0) begin
				request <= pending_q.pop_front();
				start <= 1'b1;
				if (pending_q.size() < 120) calm = 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Acceptance and result checking at the rising edge
	always @(posedge clk) begin
		c8ic_rsp_t e;
		if (arst_n && start && !busy)
			expected_q.push_back(predict_response(request));
		if (arst_n && done) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transaction result %p", result);
			end else begin
				e = expected_q.pop_front();
				if (result.read_data !== e.read_data ||
						result.program_counter !== e.program_counter ||
						result.status !== e.status ||
						result.screen_changed !== e.screen_changed ||
						result.sound_active !== e.sound_active) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch #%0d: expected %p got %p", results_seen, e, result);
				end
			end
		end
	end

	// End of run
	initial begin
		mismatches = 0; results_seen = 0; exec_count = 0; draw_count = 0;
		wait (arst_n);
		wait (pending_q.size() == 0 && !start);
		wait (expected_q.size() == 0);
		repeat (200) @(posedge clk);
		$display("%0d transactions checked, %0d instructions executed, %0d screen updates",
			results_seen, exec_count, draw_count);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("tb_chip8_instruction_core: clean");
		else
			$display("tb_chip8_instruction_core: errors");
		$finish;
	end

	// Watchdog
	initial begin
		#20ms;
		$display("tb_chip8_instruction_core: errors");
		$finish;
	end

endmodule
